FILE: hw/rtl/fbpa_pkg.sv
package fbpa_pkg;

	localparam int NumBlocksDef = 8;

	localparam int BsW        = 13;
	localparam int OffW       = 16;
	localparam int AllocOffW  = 15;
	localparam int IdleW      = 4;
	localparam int StatusW    = 2;
	localparam int DivSteps   = OffW;

	localparam logic [BsW-1:0] BsReset = BsW'(16);

	localparam logic [StatusW-1:0] StOk         = 2'd0;
	localparam logic [StatusW-1:0] StEmpty      = 2'd1;
	localparam logic [StatusW-1:0] StMisaligned = 2'd2;
	localparam logic [StatusW-1:0] StRange      = 2'd3;

	typedef struct packed {
		logic load;
		logic div_step;
		logic mem_rd;
		logic commit;
	} fbpa_cmd_t;

	typedef struct packed {
		logic div_done;
	} fbpa_sts_t;

endpackage

FILE: hw/rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator with a LIFO free list of block indices.
// Input channel (in_valid / in_stall): req_type 0 allocates the head block,
// req_type 1 frees the block at byte offset block_offset from the pool start.
// Output channel (out_valid / out_stall): one word per request with status,
// alloc_offset (byte offset of the allocated block) and idle_blocks.
// cfg_we / cfg_wdata set the block size; write it only while the block is idle.
// A free runs a 16-step restoring divider (one quotient bit per cycle) to get
// the block index and the remainder; an allocate reads the link memory and
// forms the offset product in S_ALLOC, then commits.
// One request is in flight at a time; a new one is accepted in the cycle after
// the previous result is loaded, even while that result is still stalled.
// A stalled result holds in the output register; the next request finishes
// its work and then waits until the register is taken.
// Reset: all NUM_BLOCKS blocks free and chained in index order, head at block
// zero, block size 16. Link entries never written read as their reset value.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
	parameter int NUM_BLOCKS = NumBlocksDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [BsW-1:0]       cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic [OffW-1:0]      block_offset,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [StatusW-1:0]   status,
	output logic [AllocOffW-1:0] alloc_offset,
	output logic [IdleW-1:0]     idle_blocks
);

	fbpa_cmd_t cmd;
	fbpa_sts_t sts;

	fbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fbpa_dp #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req_type    (req_type),
		.block_offset(block_offset),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.alloc_offset(alloc_offset),
		.idle_blocks (idle_blocks)
	);

endmodule

FILE: hw/rtl/fbpa_ram.sv
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/fbpa_dp.sv
module fbpa_dp import fbpa_pkg::*; #(
	parameter int NUM_BLOCKS = NumBlocksDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [BsW-1:0]       cfg_wdata,
	input  logic                 req_type,
	input  logic [OffW-1:0]      block_offset,
	input  fbpa_cmd_t            cmd,
	output fbpa_sts_t            sts,
	output logic [StatusW-1:0]   status,
	output logic [AllocOffW-1:0] alloc_offset,
	output logic [IdleW-1:0]     idle_blocks
);

	localparam int IdxW  = $clog2(NUM_BLOCKS);
	localparam int LinkW = $clog2(NUM_BLOCKS + 1);
	localparam int CntW  = $clog2(DivSteps + 1);
	localparam int ProdW = LinkW + BsW;
	localparam logic [LinkW-1:0] Null = LinkW'(NUM_BLOCKS);

	logic [BsW-1:0]        bs_q;
	logic                  kind_q;
	logic [CntW-1:0]       cnt_q;
	logic [LinkW-1:0]      head_q;
	logic [LinkW-1:0]      idle_q;
	logic [NUM_BLOCKS-1:0] vld_q;

	logic [OffW-1:0]       dvd_q;
	logic [BsW-1:0]        rem_q;
	logic [ProdW-1:0]      prod_s1;
	logic [StatusW-1:0]    status_q;
	logic [AllocOffW-1:0]  off_q;
	logic [IdleW-1:0]      idle_out_q;

	logic [BsW-1:0]        bs_eff;
	logic [BsW:0]          trial;
	logic [BsW:0]          diff;
	logic                  ge;
	logic                  step;
	logic [IdxW-1:0]       head_idx;
	logic [IdxW-1:0]       blk_idx;
	logic [LinkW-1:0]      rd_link;
	logic [LinkW-1:0]      link;
	logic                  empty;
	logic                  misaligned;
	logic                  out_range;
	logic                  push;
	logic [StatusW-1:0]    st_n;
	logic [AllocOffW-1:0]  off_n;
	logic [LinkW-1:0]      head_n;
	logic [LinkW-1:0]      idle_n;

	assign bs_eff = (bs_q == '0) ? BsW'(1) : bs_q;

	// restoring divide, one quotient bit per step
	assign trial = {rem_q, dvd_q[OffW-1]};
	assign diff  = trial - {1'b0, bs_eff};
	assign ge    = (trial >= {1'b0, bs_eff});
	assign step  = cmd.div_step && (cnt_q != '0);

	assign sts.div_done = (cnt_q == '0);

	assign head_idx   = head_q[IdxW-1:0];
	assign blk_idx    = dvd_q[IdxW-1:0];
	assign empty      = (head_q == Null);
	assign misaligned = (rem_q != '0);
	assign out_range  = (dvd_q >= OffW'(NUM_BLOCKS));
	assign push       = kind_q && !misaligned && !out_range;

	// never-written links read as their reset chain value
	assign link = vld_q[head_idx] ? rd_link : head_q + LinkW'(1);

	fbpa_ram #(
		.WIDTH(LinkW),
		.DEPTH(NUM_BLOCKS)
	) u_link_ram (
		.clk  (clk),
		.we   (cmd.commit && push),
		.waddr(blk_idx),
		.wdata(head_q),
		.re   (cmd.mem_rd),
		.raddr(head_idx),
		.rdata(rd_link)
	);

	always_comb begin
		st_n   = StOk;
		off_n  = '0;
		head_n = head_q;
		idle_n = idle_q;
		if (!kind_q) begin
			if (empty) begin
				st_n = StEmpty;
			end else begin
				off_n  = prod_s1[AllocOffW-1:0];
				head_n = link;
				if (idle_q != '0) begin
					idle_n = idle_q - LinkW'(1);
				end
			end
		end else if (misaligned) begin
			st_n = StMisaligned;
		end else if (out_range) begin
			st_n = StRange;
		end else begin
			head_n = LinkW'(blk_idx);
			if (idle_q < Null) begin
				idle_n = idle_q + LinkW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q   <= BsReset;
			kind_q <= 1'b0;
			cnt_q  <= '0;
			head_q <= '0;
			idle_q <= Null;
			vld_q  <= '0;
		end else begin
			if (cfg_we) begin
				bs_q <= cfg_wdata;
			end
			if (cmd.load) begin
				kind_q <= req_type;
				cnt_q  <= CntW'(DivSteps);
			end else if (step) begin
				cnt_q <= cnt_q - CntW'(1);
			end
			if (cmd.commit) begin
				head_q <= head_n;
				idle_q <= idle_n;
				if (push) begin
					vld_q[blk_idx] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q <= block_offset;
			rem_q <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[OffW-2:0], ge};
			rem_q <= ge ? diff[BsW-1:0] : trial[BsW-1:0];
		end
		if (cmd.mem_rd) begin
			prod_s1 <= ProdW'(head_q) * ProdW'(bs_eff);
		end
		if (cmd.commit) begin
			status_q   <= st_n;
			off_q      <= off_n;
			idle_out_q <= IdleW'(idle_n);
		end
	end

	assign status       = status_q;
	assign alloc_offset = off_q;
	assign idle_blocks  = idle_out_q;

endmodule

FILE: hw/rtl/fbpa_ctrl.sv
module fbpa_ctrl import fbpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      req_type,
	output logic      out_valid,
	input  logic      out_stall,
	input  fbpa_sts_t sts,
	output fbpa_cmd_t cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_ALLOC  = 2'd1;
	localparam logic [1:0] S_DIV    = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       out_valid_q;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	assign cmd.load     = accept;
	assign cmd.mem_rd   = (state_q == S_ALLOC);
	assign cmd.div_step = (state_q == S_DIV) && !sts.div_done;
	// hold the result until the output register frees up
	assign cmd.commit   = (state_q == S_FINISH) && (!out_valid_q || !out_stall);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_n = req_type ? S_DIV : S_ALLOC;
				end
			end
			S_ALLOC: begin
				state_n = S_FINISH;
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_n = S_FINISH;
				end
			end
			S_FINISH: begin
				if (cmd.commit) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/fbpa_checker.sv
module fbpa_checker import fbpa_pkg::*; #(
	parameter int NUM_BLOCKS = NumBlocksDef
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [StatusW-1:0]   status,
	input logic [AllocOffW-1:0] alloc_offset,
	input logic [IdleW-1:0]     idle_blocks
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(alloc_offset) && $stable(idle_blocks))
		else $error("stalled output word changed");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while one is in flight");

	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != StOk) |-> alloc_offset == '0)
		else $error("nonzero offset on a failed or ignored request");

	a_idle_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (NUM_BLOCKS < 16) |-> idle_blocks <= IdleW'(NUM_BLOCKS))
		else $error("idle count above pool size");

endmodule

bind fixed_block_pool_allocator fbpa_checker #(
	.NUM_BLOCKS(NUM_BLOCKS)
) u_fbpa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.alloc_offset(alloc_offset),
	.idle_blocks (idle_blocks)
);

FILE: verif/fixed_block_pool_allocator_tb.sv
`timescale 1ns / 100ps

module fixed_block_pool_allocator_tb;
	import fbpa_pkg::*;

	localparam int NumBlocks = NumBlocksDef;
	localparam int IdxW      = $clog2(NumBlocks + 1);
	localparam int MaxGap    = 12;

	localparam logic ReqAlloc = 1'b0;
	localparam logic ReqFree  = 1'b1;

	typedef struct packed {
		logic [StatusW-1:0]   status;
		logic [AllocOffW-1:0] offset;
		logic [IdleW-1:0]     idle;
	} pool_reply_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [BsW-1:0]       cfg_wdata    = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic                 req_type     = 1'b0;
	logic [OffW-1:0]      block_offset = '0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [StatusW-1:0]   status;
	logic [AllocOffW-1:0] alloc_offset;
	logic [IdleW-1:0]     idle_blocks;

	// shadow copy of the pool
	logic [IdxW-1:0] shadow_link [NumBlocks];
	logic [IdxW-1:0] shadow_head;
	logic [IdxW-1:0] shadow_idle;
	logic [BsW-1:0]  shadow_block_bytes;
	bit              handed_out [NumBlocks];

	pool_reply_t pending_replies [$];
	int          error_count = 0;
	bit          no_idle     = 1'b0;
	int          rx_hold_len = 0;

	fixed_block_pool_allocator #(
		.NUM_BLOCKS(NumBlocks)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.block_offset(block_offset),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.alloc_offset(alloc_offset),
		.idle_blocks (idle_blocks)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void flag_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	function automatic int unsigned pool_stride();
		return (shadow_block_bytes == '0) ? 1 : int'(shadow_block_bytes);
	endfunction

	function automatic void reset_shadow_pool();
		for (int i = 0; i < NumBlocks; i++) begin
			shadow_link[i] = IdxW'(i + 1);
			handed_out[i]  = 1'b0;
		end
		shadow_head        = '0;
		shadow_idle        = IdxW'(NumBlocks);
		shadow_block_bytes = BsReset;
	endfunction

	// pop or push the free list and queue the reply the block owes
	function automatic void apply_pool_request(input logic kind, input logic [OffW-1:0] offset);
		int unsigned stride;
		int unsigned blk;
		pool_reply_t r;
		stride   = pool_stride();
		r        = '0;
		r.status = StOk;
		if (kind == ReqAlloc) begin
			if (shadow_head >= NumBlocks) begin
				r.status = StEmpty;
			end else begin
				blk         = shadow_head;
				r.offset    = AllocOffW'(blk * stride);
				shadow_head = (shadow_link[blk] > NumBlocks) ? IdxW'(NumBlocks) : shadow_link[blk];
				handed_out[blk] = 1'b1;
				if (shadow_idle > 0)
					shadow_idle--;
			end
		end else if (offset % stride != 0) begin
			r.status = StMisaligned;
		end else begin
			blk = offset / stride;
			if (blk >= NumBlocks) begin
				r.status = StRange;
			end else begin
				shadow_link[blk] = shadow_head;
				shadow_head      = IdxW'(blk);
				handed_out[blk]  = 1'b0;
				if (shadow_idle < NumBlocks)
					shadow_idle++;
			end
		end
		r.idle = IdleW'(shadow_idle);
		pending_replies.push_back(r);
	endfunction

	// offset the block must ignore: misaligned or past the pool
	function automatic logic [OffW-1:0] stray_offset();
		int unsigned stride;
		int unsigned off;
		stride = pool_stride();
		if (stride == 1 || $urandom_range(0, 1)) begin
			off = $urandom_range(NumBlocks * stride, 65535);
		end else begin
			do off = $urandom_range(0, 65535); while (off % stride == 0);
		end
		return OffW'(off);
	endfunction

	task automatic send_request(input logic kind, input logic [OffW-1:0] offset);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MaxGap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= kind;
		block_offset <= offset;
		do @(posedge clk); while (in_stall);
		apply_pool_request(kind, offset);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
	endtask

	task automatic write_block_size(input logic [BsW-1:0] bytes);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= bytes;
		@(posedge clk);
		cfg_we    <= 1'b0;
		shadow_block_bytes = bytes;
	endtask

	// mostly allocs and frees of blocks currently handed out, some stray frees
	task automatic run_traffic(input int count);
		int done;
		int roll;
		int owned [$];
		done = 0;
		while (done < count) begin
			owned.delete();
			for (int i = 0; i < NumBlocks; i++)
				if (handed_out[i])
					owned.push_back(i);
			roll = $urandom_range(0, 99);
			if (roll < 45 || (roll < 85 && owned.size() == 0)) begin
				send_request(ReqAlloc, OffW'($urandom));
				done++;
			end else if (roll < 85) begin
				send_request(ReqFree,
					OffW'(owned[$urandom_range(0, owned.size() - 1)] * pool_stride()));
				done++;
			end else begin
				send_request(ReqFree, stray_offset());
			end
		end
	endtask

	task automatic test_directed();
		for (int i = 0; i < NumBlocks; i++)
			send_request(ReqAlloc, (i % 2) ? 16'hFFFF : 16'h0000);
		send_request(ReqAlloc, 16'h0000);
		send_request(ReqFree, 16'hFFFF);
		send_request(ReqFree, 16'hFFF0);
		send_request(ReqFree, OffW'(NumBlocks * 16));
		send_request(ReqFree, OffW'((NumBlocks - 1) * 16));
		send_request(ReqFree, 16'h0000);
		send_request(ReqAlloc, 16'h0000);
		send_request(ReqAlloc, 16'hFFFF);
		// zero block size acts as one byte
		write_block_size('0);
		send_request(ReqFree, OffW'(NumBlocks + 1));
		send_request(ReqFree, 16'hFFFF);
		send_request(ReqFree, 16'd5);
		send_request(ReqAlloc, 16'h0000);
		// largest size: last block's offset overflows the result field
		write_block_size('1);
		send_request(ReqFree, OffW'((NumBlocks - 1) * 8191));
		send_request(ReqAlloc, 16'h0000);
		send_request(ReqFree, 16'd8190);
	endtask

	task automatic test_block_sizes();
		logic [BsW-1:0] sizes [$];
		sizes = '{13'd5, 13'd4096, 13'd1, 13'd2, 13'd8191, 13'd24, BsReset,
			BsW'($urandom_range(5, 4096)), BsW'($urandom_range(0, 8191))};
		foreach (sizes[i]) begin
			write_block_size(sizes[i]);
			no_idle = (i % 3 == 2);
			run_traffic(160);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_backpressure();
		wait_drained();
		no_idle     = 1'b1;
		rx_hold_len = 300;
		run_traffic(24);
		// hold the sender until the backlog is gone
		wait_drained();
		no_idle = 1'b0;
	endtask

	task automatic test_double_free();
		wait_drained();
		for (int i = 0; i < NumBlocks; i++)
			if (handed_out[i])
				send_request(ReqFree, OffW'(i * pool_stride()));
		// head block freed again links to itself; the count saturates
		send_request(ReqFree, OffW'(shadow_head * pool_stride()));
		for (int i = 0; i < NumBlocks + 4; i++)
			send_request(ReqAlloc, OffW'($urandom));
	endtask

	initial begin : result_checker
		pool_reply_t want;
		int pause;
		forever begin
			@(posedge clk);
			pause = 0;
			if (out_valid && !out_stall) begin
				if (pending_replies.size() == 0) begin
					flag_error($sformatf("unexpected word: status %0d offset %0d idle %0d",
						status, alloc_offset, idle_blocks));
				end else begin
					want = pending_replies.pop_front();
					if (status !== want.status)
						flag_error($sformatf("status: expected %0d, got %0d",
							want.status, status));
					if (alloc_offset !== want.offset)
						flag_error($sformatf("alloc_offset: expected %0d, got %0d",
							want.offset, alloc_offset));
					if (idle_blocks !== want.idle)
						flag_error($sformatf("idle_blocks: expected %0d, got %0d",
							want.idle, idle_blocks));
				end
				pause = no_idle ? 0 : $urandom_range(0, MaxGap);
			end
			if (rx_hold_len > pause) begin
				pause       = rx_hold_len;
				rx_hold_len = 0;
			end
			if (pause > 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		reset_shadow_pool();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_block_sizes();
		test_backpressure();
		test_double_free();
		wait_drained();
		repeat (40) @(posedge clk);
		if (pending_replies.size() != 0)
			flag_error($sformatf("%0d words never arrived", pending_replies.size()));
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
